FILE: rtl/scd_pkg.sv
// Shared types, constants and helpers for the serial clock divider search.
// No dependencies; every other file in rtl/ imports this package.
package scd_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned N_W     = 6;
  localparam int unsigned PRE_W   = 13;
  localparam int unsigned OFF_W   = 2;
  localparam int unsigned DSR_W   = 38;
  localparam int unsigned CNT_W   = 5;

  localparam logic [WORD_W-1:0] BYPASS_WORD  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] SLOWEST_WORD = 32'h7FFF_F000;
  localparam logic [WORD_W-1:0] CLK_RESET    = 32'd80_000_000;
  localparam logic [N_W-1:0]    N_FIRST      = 6'd1;
  localparam logic [N_W-1:0]    N_LAST       = 6'h3F;
  localparam logic [PRE_W-1:0]  PRE_MAX      = 13'h1FFF;
  localparam logic [OFF_W-1:0]  OFF_LAST     = 2'd3;
  localparam int unsigned       SLOW_SHIFT   = 19;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BASE,
    ST_BASE_WAIT,
    ST_PRE,
    ST_RATE,
    ST_RATE_WAIT,
    ST_EVAL,
    ST_DONE
  } srch_state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
  } srch_res_t;

  // L = (N+1)/2, H = 0, bypass = 0
  function automatic logic [WORD_W-1:0] pack_word(input logic [N_W-1:0] n,
                                                  input logic [PRE_W-1:0] pre);
    logic [N_W:0] np1;
    np1 = {1'b0, n} + 7'd1;
    return {1'b0, pre, n, 6'b0, np1[N_W:1]};
  endfunction

endpackage

FILE: rtl/spi_clock_divider_search.sv
// Top level of the serial clock divider search: config register, output register.
// Depends on scd_pkg and scd_search (which holds scd_div).
//
//  channel | direction | word                  | handshake
//  --------+-----------+-----------------------+-------------------------
//  in_     | in        | target_freq, 32 bits  | in_valid / in_ready
//  out_    | out       | clock_word, 32 bits   | out_valid / out_ready
//  cfg_    | in        | system_clock_hz, 32 b | cfg_valid / cfg_ready
//
// Bypass and slowest-setting words skip the divider: ST_CHECK goes straight to ST_DONE.
// Every division goes through the one bit-serial divider, five per value of N
// in a full sweep; an exact match stops the sweep early.
// Reset loads system_clock_hz = 80000000 and empties the output register.
// in_ready drops while a word is being searched; a result moves to the output
// register as soon as it is free, so the next word is accepted while out_ready is low.
module spi_clock_divider_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scd_pkg::WORD_W-1:0]  in_target_freq,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scd_pkg::WORD_W-1:0]  out_clock_word,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [scd_pkg::WORD_W-1:0]  cfg_system_clock_hz
);
  import scd_pkg::*;

  logic [WORD_W-1:0] clk_hz_r, clk_hz_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;

  logic              srch_idle;
  srch_res_t         srch_res;
  logic              res_take;

  // take the search result when the output register is empty or draining
  assign res_take = srch_res.valid && (!out_valid_r || out_ready);

  always_comb begin
    clk_hz_nxt    = clk_hz_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (cfg_valid) clk_hz_nxt = cfg_system_clock_hz;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = srch_res.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r    <= CLK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      clk_hz_r    <= clk_hz_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  scd_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (in_valid && in_ready),
    .target_i    (in_target_freq),
    .clk_hz_i    (clk_hz_r),
    .idle_o      (srch_idle),
    .res_o       (srch_res),
    .res_ready_i (res_take)
  );

  assign in_ready       = srch_idle;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_clock_word = out_word_r;

endmodule

FILE: rtl/scd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, 32 steps.
// Depends on scd_pkg for widths and the request/response structs.
module scd_div (
  input  logic             clk,
  input  logic             rst_n,
  input  scd_pkg::div_req_t req_i,
  output scd_pkg::div_rsp_t rsp_o
);
  import scd_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [WORD_W-1:0]   rem_r, rem_nxt;
  logic [WORD_W-1:0]   quo_r, quo_nxt;
  logic [DSR_W-1:0]    dsr_r, dsr_nxt;

  logic [WORD_W:0]     shifted;
  logic [DSR_W-1:0]    diff;
  logic                qbit;

  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign qbit    = {{(DSR_W-WORD_W-1){1'b0}}, shifted} >= dsr_r;
  assign diff    = {{(DSR_W-WORD_W-1){1'b0}}, shifted} - dsr_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req_i.dividend;
      dsr_nxt  = req_i.divisor;
    end else if (busy_r) begin
      // remainder never exceeds the dividend, so 32 bits hold it
      rem_nxt = qbit ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp_o.done     = done_r;
  assign rsp_o.quotient = quo_r;

endmodule

FILE: rtl/scd_search.sv
// Search sequencer: early-out checks, then N x offset sweep through one divider.
// Depends on scd_pkg and scd_div.
module scd_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [scd_pkg::WORD_W-1:0]  target_i,
  input  logic [scd_pkg::WORD_W-1:0]  clk_hz_i,
  output logic                        idle_o,
  output scd_pkg::srch_res_t          res_o,
  input  logic                        res_ready_i
);
  import scd_pkg::*;

  srch_state_t         state_r, state_nxt;
  logic [WORD_W-1:0]   target_r, target_nxt;
  logic [N_W-1:0]      n_r, n_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [WORD_W-1:0]   q_r, q_nxt;
  logic [PRE_W-1:0]    pre_r, pre_nxt;
  logic [WORD_W-1:0]   rate_r, rate_nxt;
  logic [WORD_W-1:0]   best_rate_r, best_rate_nxt;
  logic [WORD_W-1:0]   best_word_r, best_word_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [N_W:0]        np1;
  logic [PRE_W:0]      pp1;
  logic [N_W+WORD_W:0] base_prod;
  logic [PRE_W+N_W+1:0] rate_prod;
  logic [WORD_W+1:0]   p_sum;
  logic [PRE_W-1:0]    pre_clamp;
  logic                bypass, slowest, hit, better;
  logic [WORD_W-1:0]   cand;

  assign np1       = {1'b0, n_r} + 7'd1;
  assign pp1       = {1'b0, pre_r} + 14'd1;
  assign base_prod = {{WORD_W{1'b0}}, np1} * {{(N_W+1){1'b0}}, target_r};
  assign rate_prod = {{(N_W+1){1'b0}}, pp1} * {{(PRE_W+1){1'b0}}, np1};

  // candidate pre = floor estimate - 2 + offset code, clamped to 0..PRE_MAX
  assign p_sum = {2'b00, q_r} + {{WORD_W{1'b0}}, off_r} - 34'd2;
  always_comb begin
    if (p_sum[WORD_W+1] || (p_sum == '0)) begin
      pre_clamp = '0;
    end else if (|p_sum[WORD_W:PRE_W]) begin
      pre_clamp = PRE_MAX;
    end else begin
      pre_clamp = p_sum[PRE_W-1:0];
    end
  end

  assign bypass  = target_r >= clk_hz_i;
  assign slowest = (target_r == '0) || (target_r < (clk_hz_i >> SLOW_SHIFT));
  assign hit     = rate_r == target_r;
  assign better  = (rate_r < target_r) && (rate_r > best_rate_r);
  assign cand    = pack_word(n_r, pre_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (start_i) state_nxt = ST_CHECK;
      ST_CHECK:     state_nxt = (bypass || slowest) ? ST_DONE : ST_BASE;
      ST_BASE:      state_nxt = ST_BASE_WAIT;
      ST_BASE_WAIT: if (div_rsp.done) state_nxt = ST_PRE;
      ST_PRE:       state_nxt = ST_RATE;
      ST_RATE:      state_nxt = ST_RATE_WAIT;
      ST_RATE_WAIT: if (div_rsp.done) state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (hit) begin
          state_nxt = ST_DONE;
        end else if (off_r != OFF_LAST) begin
          state_nxt = ST_PRE;
        end else if (n_r == N_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_BASE;
        end
      end
      ST_DONE:      if (res_ready_i) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    target_nxt    = target_r;
    n_nxt         = n_r;
    off_nxt       = off_r;
    q_nxt         = q_r;
    pre_nxt       = pre_r;
    rate_nxt      = rate_r;
    best_rate_nxt = best_rate_r;
    best_word_nxt = best_word_r;
    word_nxt      = word_r;
    div_req.start    = 1'b0;
    div_req.dividend = clk_hz_i;
    div_req.divisor  = base_prod[DSR_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (start_i) target_nxt = target_i;
      end
      ST_CHECK: begin
        n_nxt         = N_FIRST;
        best_rate_nxt = '0;
        best_word_nxt = '0;
        if (bypass) begin
          word_nxt = BYPASS_WORD;
        end else if (slowest) begin
          word_nxt = SLOWEST_WORD;
        end
      end
      ST_BASE: begin
        div_req.start = 1'b1;
      end
      ST_BASE_WAIT: begin
        q_nxt   = div_rsp.quotient;
        off_nxt = '0;
      end
      ST_PRE: begin
        pre_nxt = pre_clamp;
      end
      ST_RATE: begin
        div_req.start   = 1'b1;
        div_req.divisor = {{(DSR_W-PRE_W-N_W-2){1'b0}}, rate_prod};
      end
      ST_RATE_WAIT: begin
        rate_nxt = div_rsp.quotient;
      end
      ST_EVAL: begin
        off_nxt = off_r + 1'b1;
        if (better) begin
          best_rate_nxt = rate_r;
          best_word_nxt = cand;
        end
        if (hit) begin
          word_nxt = cand;
        end else if (off_r == OFF_LAST) begin
          n_nxt    = n_r + 1'b1;
          word_nxt = better ? cand : best_word_r;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    target_r    <= target_nxt;
    n_r         <= n_nxt;
    off_r       <= off_nxt;
    q_r         <= q_nxt;
    pre_r       <= pre_nxt;
    rate_r      <= rate_nxt;
    best_rate_r <= best_rate_nxt;
    best_word_r <= best_word_nxt;
    word_r      <= word_nxt;
  end

  scd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign idle_o      = state_r == ST_IDLE;
  assign res_o.valid = state_r == ST_DONE;
  assign res_o.word  = word_r;

endmodule

FILE: rtl/scd_checker.sv
// Port-level checks for spi_clock_divider_search, bound to the top level.
// Depends on scd_pkg for field constants.
module scd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [scd_pkg::WORD_W-1:0]  out_clock_word
);
  import scd_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_clock_word))
    else $error("result word changed while stalled");

  // one word in flight: drop in_ready right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted during a search");

  // bypass flag only appears in the plain bypass word
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clock_word[WORD_W-1] |-> out_clock_word == BYPASS_WORD)
    else $error("bypass flag with nonzero divider fields");

  // H field is never set
  a_h_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_clock_word[11:6] == 6'b0)
    else $error("H field nonzero");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spi_clock_divider_search scd_checker u_scd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_clock_word (out_clock_word)
);
